// ----- rtl/core/mrsfc_pkg.sv -----
// Package for the Modbus RTU slave frame checker.
// Holds the verdict codes, config register indexes, the judgment struct and the CRC step.
// No dependencies.
package mrsfc_pkg;

    // CRC-16/Modbus constants
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    // Frame and reply constants
    localparam logic [7:0] EXC_FLAG       = 8'h80;
    localparam logic [7:0] EXC_ILLEGAL    = 8'h01;
    localparam logic [7:0] BROADCAST_ADDR = 8'h00;
    localparam int         MIN_FRAME      = 4;
    localparam int         COUNT_W        = 3;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
    localparam logic [COUNT_W-1:0] MIN_POS   = COUNT_W'(MIN_FRAME - 1);
    localparam logic [COUNT_W-1:0] POS_ADDR  = COUNT_W'(0);
    localparam logic [COUNT_W-1:0] POS_FUNC  = COUNT_W'(1);
    localparam logic [COUNT_W-1:0] POS_CRC   = COUNT_W'(2);

    // Config port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;
    localparam int MAP_WORDS  = 4;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SLAVE_ADDR = 3'd0,
        CFG_MAP_0      = 3'd1,
        CFG_MAP_1      = 3'd2,
        CFG_MAP_2      = 3'd3,
        CFG_MAP_3      = 3'd4
    } t_cfg_idx;

    // Result verdicts
    typedef enum logic [1:0] {
        VERDICT_IGNORE = 2'd0,
        VERDICT_PASS   = 2'd1,
        VERDICT_EXC    = 2'd2
    } t_verdict;

    // Frame judgment handed from the frame tracker to the reply sequencer
    typedef struct packed {
        logic       valid;
        t_verdict   verdict;
        logic [7:0] func;
        logic [7:0] addr;
    } t_judgment;

    // One byte of CRC-16/Modbus, reflected, LSB first
    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                             input logic [7:0] data);
        logic [15:0] c;
        c = crc_in ^ {8'h00, data};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

// ----- rtl/core/mrsfc_in_if.sv -----
// Input byte channel of the Modbus RTU slave frame checker.
// Carries one frame byte and its end-of-frame mark per beat. No dependencies.
interface mrsfc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       last_byte;

    modport source(output valid, output rx_byte, output last_byte, input ready);
    modport sink(input valid, input rx_byte, input last_byte, output ready);
endinterface

// ----- rtl/core/mrsfc_out_if.sv -----
// Result channel of the Modbus RTU slave frame checker.
// Carries verdict, function code, reply byte and run end per beat. No dependencies.
interface mrsfc_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] verdict;
    logic [7:0] func_code;
    logic [7:0] tx_byte;
    logic       last_of_run;

    modport source(output valid, output verdict, output func_code, output tx_byte,
                   output last_of_run, input ready);
    modport sink(input valid, input verdict, input func_code, input tx_byte,
                 input last_of_run, output ready);
endinterface

// ----- rtl/core/mrsfc_frame.sv -----
// Frame tracker: config registers, per-frame state, running CRC and the end-of-frame judgment.
// Depends on mrsfc_pkg and mrsfc_in_if.
module mrsfc_frame (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [mrsfc_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [mrsfc_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    mrsfc_in_if.sink                             i_in,
    output mrsfc_pkg::t_judgment                 o_jud,
    input  logic                                 i_jud_ready
);
    import mrsfc_pkg::*;

    // Config registers
    logic [7:0]            r_slave_addr;
    logic [CFG_DATA_W-1:0] r_map [MAP_WORDS];

    // Frame state
    logic [COUNT_W-1:0] r_count, n_count;
    logic [7:0]         r_addr, n_addr;
    logic [7:0]         r_func, n_func;
    logic [7:0]         r_held [2];
    logic [7:0]         n_held [2];
    logic [15:0]        r_crc, n_crc;

    // Judgment slot
    t_judgment r_jud, n_jud;

    logic        accept;
    logic [15:0] crc_now;
    logic [7:0]  addr_now;
    logic [7:0]  func_now;
    logic        frame_ok;
    logic        code_hit;
    logic [CFG_DATA_W-1:0] map_word;

    assign i_in.ready = !r_jud.valid || i_jud_ready;
    assign accept     = i_in.valid && i_in.ready;
    assign o_jud      = r_jud;

    // Config writes; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slave_addr <= 8'd1;
            for (int w = 0; w < MAP_WORDS; w++) begin
                r_map[w] <= '0;
            end
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_SLAVE_ADDR: r_slave_addr <= i_cfg_data[7:0];
                CFG_MAP_0:      r_map[0] <= i_cfg_data;
                CFG_MAP_1:      r_map[1] <= i_cfg_data;
                CFG_MAP_2:      r_map[2] <= i_cfg_data;
                CFG_MAP_3:      r_map[3] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // CRC covers the byte two places back, so the check bytes stay out of it
    always_comb begin
        crc_now  = (r_count >= POS_CRC) ? crc_byte(r_crc, r_held[1]) : r_crc;
        addr_now = (r_count == POS_ADDR) ? i_in.rx_byte : r_addr;
        func_now = (r_count == POS_FUNC) ? i_in.rx_byte : r_func;
        frame_ok = (r_count >= MIN_POS)
                && (addr_now != BROADCAST_ADDR)
                && (addr_now == r_slave_addr)
                && (r_held[0] == crc_now[7:0])
                && (i_in.rx_byte == crc_now[15:8]);
        map_word = r_map[func_now[7:6]];
        code_hit = map_word[func_now[5:0]];
    end

    // Next frame state and judgment slot
    always_comb begin
        n_count = r_count;
        n_addr  = r_addr;
        n_func  = r_func;
        n_held  = r_held;
        n_crc   = r_crc;
        n_jud   = r_jud;
        if (i_jud_ready) begin
            n_jud.valid = 1'b0;
        end
        if (accept) begin
            if (i_in.last_byte) begin
                // frame end: judge and return to the reset state
                n_count       = '0;
                n_addr        = '0;
                n_func        = '0;
                n_held[0]     = '0;
                n_held[1]     = '0;
                n_crc         = CRC_INIT;
                n_jud.valid   = 1'b1;
                n_jud.func    = func_now;
                n_jud.addr    = addr_now;
                if (!frame_ok) begin
                    n_jud.verdict = VERDICT_IGNORE;
                end else if (code_hit) begin
                    n_jud.verdict = VERDICT_PASS;
                end else begin
                    n_jud.verdict = VERDICT_EXC;
                end
            end else begin
                n_count   = (r_count == COUNT_MAX) ? r_count : r_count + 1'b1;
                n_addr    = addr_now;
                n_func    = func_now;
                n_held[1] = r_held[0];
                n_held[0] = i_in.rx_byte;
                n_crc     = crc_now;
            end
        end
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_addr      <= '0;
            r_func      <= '0;
            r_held[0]   <= '0;
            r_held[1]   <= '0;
            r_crc       <= CRC_INIT;
        end else begin
            r_count     <= n_count;
            r_addr      <= n_addr;
            r_func      <= n_func;
            r_held      <= n_held;
            r_crc       <= n_crc;
        end
    end

    // Judgment slot; only the valid flag is reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_jud.valid <= 1'b0;
        end else begin
            r_jud.valid <= n_jud.valid;
        end
        r_jud.verdict <= n_jud.verdict;
        r_jud.func    <= n_jud.func;
        r_jud.addr    <= n_jud.addr;
    end

endmodule

// ----- rtl/core/mrsfc_reply.sv -----
// Reply sequencer: turns a judgment into one result beat or a five-beat exception reply.
// Depends on mrsfc_pkg and mrsfc_out_if.
module mrsfc_reply (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  mrsfc_pkg::t_judgment i_jud,
    output logic                 o_jud_ready,
    mrsfc_out_if.source          o_out
);
    import mrsfc_pkg::*;

    // State names the next exception byte to send
    typedef enum logic [4:0] {
        RS_IDLE   = 5'b00001,
        RS_FUNC   = 5'b00010,
        RS_CODE   = 5'b00100,
        RS_CRC_LO = 5'b01000,
        RS_CRC_HI = 5'b10000
    } t_reply_state;

    t_reply_state r_state, n_state;
    logic         r_valid, n_valid;
    t_verdict     r_verdict, n_verdict;
    logic [7:0]   r_func, n_func;
    logic [7:0]   r_tx, n_tx;
    logic         r_last, n_last;
    logic [15:0]  r_crc, n_crc;

    logic advance;

    assign advance = !r_valid || o_out.ready;

    assign o_out.valid       = r_valid;
    assign o_out.verdict     = r_verdict;
    assign o_out.func_code   = r_func;
    assign o_out.tx_byte     = r_tx;
    assign o_out.last_of_run = r_last;

    // Load the output register with the next beat
    always_comb begin
        n_state     = r_state;
        n_valid     = r_valid;
        n_verdict   = r_verdict;
        n_func      = r_func;
        n_tx        = r_tx;
        n_last      = r_last;
        n_crc       = r_crc;
        o_jud_ready = 1'b0;
        if (advance) begin
            n_valid = 1'b1;
            case (r_state)
                RS_IDLE: begin
                    o_jud_ready = 1'b1;
                    n_valid     = i_jud.valid;
                    n_verdict   = i_jud.verdict;
                    n_func      = i_jud.func;
                    if (i_jud.verdict == VERDICT_EXC) begin
                        n_tx  = i_jud.addr;
                        n_last = 1'b0;
                        n_crc = crc_byte(CRC_INIT, i_jud.addr);
                        if (i_jud.valid) begin
                            n_state = RS_FUNC;
                        end
                    end else begin
                        n_tx   = 8'h00;
                        n_last = 1'b1;
                    end
                end
                RS_FUNC: begin
                    n_tx    = r_func | EXC_FLAG;
                    n_last  = 1'b0;
                    n_crc   = crc_byte(r_crc, r_func | EXC_FLAG);
                    n_state = RS_CODE;
                end
                RS_CODE: begin
                    n_tx    = EXC_ILLEGAL;
                    n_last  = 1'b0;
                    n_crc   = crc_byte(r_crc, EXC_ILLEGAL);
                    n_state = RS_CRC_LO;
                end
                RS_CRC_LO: begin
                    n_tx    = r_crc[7:0];
                    n_last  = 1'b0;
                    n_state = RS_CRC_HI;
                end
                RS_CRC_HI: begin
                    n_tx    = r_crc[15:8];
                    n_last  = 1'b1;
                    n_state = RS_IDLE;
                end
                default: begin
                    n_valid = 1'b0;
                    n_state = RS_IDLE;
                end
            endcase
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= RS_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_verdict <= n_verdict;
        r_func    <= n_func;
        r_tx      <= n_tx;
        r_last    <= n_last;
        r_crc     <= n_crc;
    end

endmodule

// ----- rtl/core/modbus_rtu_slave_frame_checker.sv -----
// Top level of the Modbus RTU slave frame checker.
// Depends on mrsfc_pkg, mrsfc_in_if, mrsfc_out_if, mrsfc_frame and mrsfc_reply.
//
//   channel   dir  beat contents                              handshake
//   i_in      in   rx_byte[7:0], last_byte                    valid/ready
//   o_out     out  verdict[1:0], func_code[7:0], tx_byte[7:0], last_of_run  valid/ready
//   cfg       in   i_cfg_idx[2:0], i_cfg_data[63:0]           i_cfg_we
//
// One byte is taken per cycle while the judgment slot is free; the byte-wide CRC step
// and the frame checks sit between the frame state registers and a one-entry judgment slot.
// A frame end loads the slot, and the reply sequencer moves it to its output register; an
// exception reply then sends one byte per ready cycle, stalling input once the slot is full.
// Reset is synchronous, active low, and leaves frame state empty with slave address 1.
// Output stalls hold the result; input keeps flowing while the judgment slot is free.
module modbus_rtu_slave_frame_checker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [mrsfc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [mrsfc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    mrsfc_in_if.sink                         i_in,
    mrsfc_out_if.source                      o_out
);
    import mrsfc_pkg::*;

    t_judgment jud;
    logic      jud_ready;

    // Byte tracking and judgment
    mrsfc_frame u_frame (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in        (i_in),
        .o_jud       (jud),
        .i_jud_ready (jud_ready)
    );

    // Result beats and exception replies
    mrsfc_reply u_reply (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_jud       (jud),
        .o_jud_ready (jud_ready),
        .o_out       (o_out)
    );

endmodule

// ----- rtl/core/mrsfc_checker.sv -----
// Port-level checks for the Modbus RTU slave frame checker, with the bind that attaches them.
// Depends on mrsfc_pkg and modbus_rtu_slave_frame_checker.
module mrsfc_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [1:0] i_out_verdict,
    input logic [7:0] i_out_func_code,
    input logic [7:0] i_out_tx_byte,
    input logic       i_out_last_of_run
);
    import mrsfc_pkg::*;

    // Stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_tx_byte)
            && $stable(i_out_verdict) && $stable(i_out_last_of_run))
        else $error("result beat changed while stalled");

    // Ignore and pass verdicts are single-beat runs with no reply byte
    a_single_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_out_verdict != VERDICT_EXC) |->
            i_out_last_of_run && (i_out_tx_byte == 8'h00))
        else $error("non-exception result is not a lone zero beat");

    // Exception reply bytes follow with no gap and keep the code
    a_exc_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_ready && (i_out_verdict == VERDICT_EXC) && !i_out_last_of_run
            |=> i_out_valid && (i_out_verdict == VERDICT_EXC) && $stable(i_out_func_code))
        else $error("exception reply broken");

    // No result straight out of reset
    a_reset_idle: assert property (@(posedge i_clk)
        $rose(i_rst_n) |-> !i_out_valid)
        else $error("result valid right after reset");

endmodule

bind modbus_rtu_slave_frame_checker mrsfc_checker u_mrsfc_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_out_valid       (o_out.valid),
    .i_out_ready       (o_out.ready),
    .i_out_verdict     (o_out.verdict),
    .i_out_func_code   (o_out.func_code),
    .i_out_tx_byte     (o_out.tx_byte),
    .i_out_last_of_run (o_out.last_of_run)
);

// ----- tb/tb_top.sv -----
// Self-checking testbench for modbus_rtu_slave_frame_checker: byte frames in, verdicts out.
// A local frame tracker predicts every result beat; depends on mrsfc_pkg and the two
// channel interfaces mrsfc_in_if and mrsfc_out_if.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import mrsfc_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 16;

    typedef struct {
        t_verdict   verdict;
        logic [7:0] func;
        logic [7:0] tx;
        logic       eor;
    } t_reply_beat;

    logic i_clk;
    logic i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    mrsfc_in_if  in_ch();
    mrsfc_out_if out_ch();

    modbus_rtu_slave_frame_checker u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    // Mirror of the configuration registers
    logic [7:0]  own_addr = 8'h01;
    logic [63:0] handler_bits [MAP_WORDS] = '{default: '0};

    // Mirror of the frame tracking state
    logic [COUNT_W-1:0] trk_count = '0;
    logic [7:0]         trk_addr  = '0;
    logic [7:0]         trk_func  = '0;
    logic [7:0]         trk_hold [2] = '{default: '0};
    logic [15:0]        trk_crc   = CRC_INIT;

    t_reply_beat expected_replies [$];
    logic [7:0]  frame_buf [$];

    int mismatches     = 0;
    int cycle_count    = 0;
    int bytes_sent     = 0;
    int frames_sent    = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_req       = 0;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Run limit
    always @(posedge i_clk) begin
        cycle_count = cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("modbus_rtu_slave_frame_checker regression: fail");
            $finish;
        end
    end

    // Result-side ready: random stalls, plus long hold-offs on request
    initial begin : drive_ready
        int hold_left;
        hold_left = 0;
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req != 0) begin
                hold_left = hold_req;
                hold_req = 0;
            end
            if (hold_left != 0) begin
                out_ch.ready = 1'b0;
                hold_left--;
            end else begin
                out_ch.ready = ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // One reflected CRC-16 step, LSB first
    function automatic logic [15:0] modbus_crc_update(input logic [15:0] crc,
                                                      input logic [7:0] b);
        logic [15:0] r;
        r = crc ^ {8'h00, b};
        repeat (8) r = (r >> 1) ^ (r[0] ? CRC_POLY : 16'h0000);
        return r;
    endfunction

    function automatic void add_expected(input t_verdict v, input logic [7:0] f,
                                         input logic [7:0] t, input logic e);
        t_reply_beat r;
        r.verdict = v;
        r.func    = f;
        r.tx      = t;
        r.eor     = e;
        expected_replies.push_back(r);
    endfunction

    // Track one accepted frame byte; at the frame end, queue the reply beats
    function automatic void predict_byte(input logic [7:0] b, input logic eof);
        logic [COUNT_W-1:0] pos;
        logic               ok;
        logic [7:0]         a;
        logic [7:0]         f;
        logic [15:0]        rc;
        logic [7:0]         rep [5];
        pos = trk_count;
        if (pos == POS_ADDR) trk_addr = b;
        else if (pos == POS_FUNC) trk_func = b;
        if (pos >= POS_CRC) trk_crc = modbus_crc_update(trk_crc, trk_hold[1]);
        if (!eof) begin
            trk_hold[1] = trk_hold[0];
            trk_hold[0] = b;
            if (trk_count != COUNT_MAX) trk_count = trk_count + 1'b1;
            return;
        end
        a = trk_addr;
        f = trk_func;
        ok = (pos >= MIN_POS) && (a != BROADCAST_ADDR) && (a == own_addr)
             && (trk_hold[0] == trk_crc[7:0]) && (b == trk_crc[15:8]);
        // frame state clears whatever the verdict
        trk_count   = '0;
        trk_addr    = '0;
        trk_func    = '0;
        trk_hold[0] = '0;
        trk_hold[1] = '0;
        trk_crc     = CRC_INIT;
        if (!ok) begin
            add_expected(VERDICT_IGNORE, f, 8'h00, 1'b1);
        end else if (handler_bits[f[7:6]][f[5:0]]) begin
            add_expected(VERDICT_PASS, f, 8'h00, 1'b1);
        end else begin
            // illegal-function exception reply with its own CRC
            rep[0] = a;
            rep[1] = f | EXC_FLAG;
            rep[2] = EXC_ILLEGAL;
            rc = CRC_INIT;
            for (int k = 0; k < 3; k++) rc = modbus_crc_update(rc, rep[k]);
            rep[3] = rc[7:0];
            rep[4] = rc[15:8];
            for (int k = 0; k < 5; k++) add_expected(VERDICT_EXC, f, rep[k], k == 4);
        end
    endfunction

    // Predict on input beats, then check output beats against the oldest expectation
    always @(posedge i_clk) begin : check_replies
        t_reply_beat want;
        if (i_rst_n) begin
            if (in_ch.valid && in_ch.ready) predict_byte(in_ch.rx_byte, in_ch.last_byte);
            if (out_ch.valid && out_ch.ready) begin
                if (expected_replies.size() == 0) begin
                    $display({"%0t: unexpected beat: expected none, ",
                              "actual v=%0d f=%02h t=%02h l=%0b"},
                             $realtime, out_ch.verdict, out_ch.func_code, out_ch.tx_byte,
                             out_ch.last_of_run);
                    mismatches++;
                end else begin
                    want = expected_replies.pop_front();
                    if (out_ch.verdict !== want.verdict || out_ch.func_code !== want.func
                        || out_ch.tx_byte !== want.tx || out_ch.last_of_run !== want.eor) begin
                        $display({"%0t: beat mismatch: expected v=%0d f=%02h t=%02h l=%0b, ",
                                  "actual v=%0d f=%02h t=%02h l=%0b"},
                                 $realtime, want.verdict, want.func, want.tx, want.eor,
                                 out_ch.verdict, out_ch.func_code, out_ch.tx_byte,
                                 out_ch.last_of_run);
                        mismatches++;
                    end
                end
            end
        end
    end

    // Offer one byte beat; called at a falling edge, returns at a falling edge with valid held
    task automatic push_byte(input logic [7:0] b, input logic eof);
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid = 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid     = 1'b1;
        in_ch.rx_byte   = b;
        in_ch.last_byte = eof;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        bytes_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_frame();
        for (int k = 0; k < frame_buf.size(); k++) begin
            push_byte(frame_buf[k], k == frame_buf.size() - 1);
        end
        frames_sent++;
    endtask

    // Address, function, random payload and a correct CRC, low byte first
    function automatic void make_frame(input logic [7:0] a, input logic [7:0] f, input int n);
        logic [15:0] c;
        frame_buf = {};
        frame_buf.push_back(a);
        frame_buf.push_back(f);
        repeat (n) frame_buf.push_back(8'($urandom));
        c = CRC_INIT;
        foreach (frame_buf[k]) c = modbus_crc_update(c, frame_buf[k]);
        frame_buf.push_back(c[7:0]);
        frame_buf.push_back(c[15:8]);
    endfunction

    // Flip one bit in one of the two check bytes
    function automatic void corrupt_check();
        int k;
        k = frame_buf.size() - 1 - $urandom_range(1);
        frame_buf[k] = frame_buf[k] ^ 8'(1 << $urandom_range(7));
    endfunction

    // Stop offering, wait for every expected beat, then let the block settle
    task automatic wait_drain();
        in_ch.valid = 1'b0;
        while (expected_replies.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] v);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = v;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        case (idx)
            CFG_SLAVE_ADDR: own_addr = v[7:0];
            CFG_MAP_0, CFG_MAP_1, CFG_MAP_2, CFG_MAP_3: handler_bits[2'(idx - CFG_MAP_0)] = v;
            default: ;
        endcase
    endtask

    task automatic apply_setting(input logic [7:0] a, input logic [63:0] m0,
                                 input logic [63:0] m1, input logic [63:0] m2,
                                 input logic [63:0] m3);
        write_reg(CFG_SLAVE_ADDR, {56'h0, a});
        write_reg(CFG_MAP_0, m0);
        write_reg(CFG_MAP_1, m1);
        write_reg(CFG_MAP_2, m2);
        write_reg(CFG_MAP_3, m3);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // One random frame: mostly well formed to our address, the rest broken or noise
    task automatic random_frame();
        int kind;
        int n;
        kind = $urandom_range(99);
        n = ($urandom_range(99) < 85) ? $urandom_range(4) : $urandom_range(12, 5);
        if (kind < 70) begin
            make_frame(own_addr, 8'($urandom), n);
        end else if (kind < 78) begin
            make_frame(own_addr, 8'($urandom), n);
            corrupt_check();
        end else if (kind < 86) begin
            make_frame(own_addr ^ 8'(1 << $urandom_range(7)), 8'($urandom), n);
        end else if (kind < 90) begin
            make_frame(BROADCAST_ADDR, 8'($urandom), n);
        end else begin
            frame_buf = {};
            repeat ($urandom_range(9, 1)) frame_buf.push_back(8'($urandom));
        end
        send_frame();
    endtask

    // Reset settings, short frames, broadcast, foreign address, bad check, then a handler hit
    task automatic test_directed_frames();
        make_frame(8'h01, 8'h00, 0);
        send_frame();
        frame_buf = {8'hFF};
        send_frame();
        frame_buf = {8'h01, 8'h03};
        send_frame();
        frame_buf = {8'h01, 8'h03, 8'h00};
        send_frame();
        make_frame(BROADCAST_ADDR, 8'h03, 0);
        send_frame();
        make_frame(8'h02, 8'h03, 0);
        send_frame();
        make_frame(8'h01, 8'h03, 0);
        corrupt_check();
        send_frame();
        wait_drain();
        apply_setting(8'hFF, '0, '0, '0, 64'h8000_0000_0000_0000);
        make_frame(8'hFF, 8'hFF, 0);
        send_frame();
        wait_drain();
    endtask

    // Own address 0 still never answers a broadcast
    task automatic test_broadcast_own_zero();
        apply_setting(8'h00, '1, '1, '1, '1);
        repeat (3) begin
            make_frame(BROADCAST_ADDR, 8'($urandom), $urandom_range(3));
            send_frame();
        end
        make_frame(8'h01, 8'h10, 2);
        send_frame();
        wait_drain();
    endtask

    // Writes to indexes past the map words leave the settings alone
    task automatic test_unknown_index();
        apply_setting(8'h5A, '1, '0, '1, '0);
        for (int k = CFG_MAP_3 + 1; k < (1 << CFG_IDX_W); k++) begin
            write_reg(CFG_IDX_W'(k), rand64());
        end
        repeat (3) begin
            make_frame(8'h5A, 8'($urandom), $urandom_range(4));
            send_frame();
        end
        wait_drain();
    endtask

    // Long receiver hold-off while exception frames keep coming, so the input stalls
    task automatic test_result_backpressure();
        apply_setting(8'($urandom_range(254, 1)), '0, '0, '0, '0);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_req = 300;
        repeat (8) begin
            make_frame(own_addr, 8'($urandom), 0);
            send_frame();
        end
        wait_drain();
    endtask

    // Sender stops until all results are back, then resumes
    task automatic test_drain_pause();
        apply_setting(8'($urandom_range(254, 1)), rand64(), rand64(), rand64(), rand64());
        send_idle_pct = 25;
        recv_stall_pct = 25;
        repeat (2) random_frame();
        wait_drain();
        repeat (2) random_frame();
        wait_drain();
    endtask

    // Random traffic over the idle/stall phases, with a fresh setting in each
    task automatic test_random_traffic();
        int send_pct [4];
        int recv_pct [4];
        int b0;
        int f0;
        send_pct = '{0, 62, 0, 25};
        recv_pct = '{0, 0, 62, 25};
        for (int p = 0; p < 4; p++) begin
            case (p)
                0: apply_setting(8'hFF, rand64(), rand64(), rand64(), rand64());
                1: apply_setting(8'($urandom_range(254, 1)), '1, '0, '1, '0);
                2: apply_setting(8'h01, rand64(), rand64(), rand64(), rand64());
                default: apply_setting(8'($urandom_range(254, 1)), rand64(), rand64(),
                                       rand64(), rand64());
            endcase
            send_idle_pct = send_pct[p];
            recv_stall_pct = recv_pct[p];
            b0 = bytes_sent;
            f0 = frames_sent;
            while (bytes_sent - b0 < 12 || frames_sent - f0 < 2) random_frame();
            wait_drain();
        end
    endtask

    initial begin
        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_idx       = '0;
        i_cfg_data      = '0;
        in_ch.valid     = 1'b0;
        in_ch.rx_byte   = '0;
        in_ch.last_byte = 1'b0;
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        test_directed_frames();
        test_broadcast_own_zero();
        test_unknown_index();
        test_result_backpressure();
        test_drain_pause();
        test_random_traffic();

        wait_drain();
        if (mismatches == 0) begin
            $display("modbus_rtu_slave_frame_checker regression: pass");
        end else begin
            $display("modbus_rtu_slave_frame_checker regression: fail");
        end
        $finish;
    end

endmodule
